@@ rtl/core/pgmchk_pkg.sv @@
// ----------------------------------------------------------------------------
// pgmchk_pkg
// Shared types, constants and command/status structs of the graymap checker.
// ----------------------------------------------------------------------------
package pgmchk_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam logic [12:0] ACC_LIMIT = 13'd8191;

  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LF   = 8'h0A;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_MAGIC = 4'd1,
    ST_BAD_HDR   = 4'd2,
    ST_MAX_BIG   = 4'd3,
    ST_TOO_FEW   = 4'd4,
    ST_NEGATIVE  = 4'd5,
    ST_ABOVE_MAX = 4'd6,
    ST_TOO_MANY  = 4'd7,
    ST_BAD_CHAR  = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_STEP,
    FSM_DIV,
    FSM_OUT,
    FSM_DRAIN
  } fsm_state_t;

  typedef struct packed {
    logic step;       // apply the held byte to the parser
    logic div_start;  // begin average division
    logic div_run;    // one division step
  } dp_cmd_t;

  typedef struct packed {
    logic    emit;     // step produced a result
    logic    need_div; // result needs an average
    logic    div_done;
  } dp_sts_t;

endpackage

@@ rtl/core/pgmchk_ctrl.sv @@
// ----------------------------------------------------------------------------
// pgmchk_ctrl
// Controller: sequences byte steps, average division and result transfer.
// ----------------------------------------------------------------------------
module pgmchk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pgmchk_pkg::dp_cmd_t cmd,
  input  pgmchk_pkg::dp_sts_t sts
);

  pgmchk_pkg::fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pgmchk_pkg::FSM_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pgmchk_pkg::FSM_IDLE:  if (in_valid) state_nxt = pgmchk_pkg::FSM_STEP;
      pgmchk_pkg::FSM_STEP: begin
        if (!sts.emit)        state_nxt = pgmchk_pkg::FSM_IDLE;
        else if (sts.need_div) state_nxt = pgmchk_pkg::FSM_DIV;
        else                  state_nxt = pgmchk_pkg::FSM_OUT;
      end
      pgmchk_pkg::FSM_DIV:   if (sts.div_done) state_nxt = pgmchk_pkg::FSM_OUT;
      pgmchk_pkg::FSM_OUT:   if (out_ready) state_nxt = pgmchk_pkg::FSM_IDLE;
      default:               state_nxt = pgmchk_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.step      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_run   = 1'b0;
    unique case (state_r)
      pgmchk_pkg::FSM_IDLE: in_ready = 1'b1;
      pgmchk_pkg::FSM_STEP: begin
        cmd.step      = 1'b1;
        cmd.div_start = sts.emit && sts.need_div;
      end
      pgmchk_pkg::FSM_DIV:  cmd.div_run = 1'b1;
      pgmchk_pkg::FSM_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/pgmchk_dp.sv @@
// ----------------------------------------------------------------------------
// pgmchk_dp
// Datapath: token parser, pixel statistics and restoring average divider.
// ----------------------------------------------------------------------------
module pgmchk_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_end_of_file,
  input  pgmchk_pkg::dp_cmd_t cmd,
  output pgmchk_pkg::dp_sts_t sts,
  output logic [3:0]          out_status,
  output logic [8:0]          out_lowest_pixel,
  output logic [7:0]          out_highest_pixel,
  output logic [31:0]         out_pixel_total,
  output logic [15:0]         out_average_fixed
);

  // phase: 0 'P', 1 '2', 2..13 field*3+sub, 14 done
  logic [7:0]  byte_r;
  logic        eof_r;
  logic [3:0]  phase_r, phase_nxt;
  logic        cmt_r, cmt_nxt;
  logic [12:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt, neg_r, neg_nxt;
  logic [12:0] wid_r, wid_nxt, hgt_r, hgt_nxt;
  logic [8:0]  maxv_r, maxv_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [8:0]  low_r, low_nxt;
  logic [7:0]  high_r, high_nxt;
  logic        given_r, given_nxt;
  logic [24:0] area_r, area_nxt;
  logic [3:0]  st_r;

  logic        emit;
  logic [3:0]  emit_st;
  logic [1:0]  field, sub;
  logic [3:0]  rel;
  logic        tok_err;
  logic [3:0]  tok_st;
  logic        is_sp, is_dig, neg_eff;
  logic [16:0] acc_mul;
  logic [32:0] sum_add;

  always_comb begin
    rel   = phase_r - 4'd2;
    field = 2'd0;
    sub   = 2'd0;
    unique case (rel)
      4'd0:  begin field = 2'd0; sub = 2'd0; end
      4'd1:  begin field = 2'd0; sub = 2'd1; end
      4'd2:  begin field = 2'd0; sub = 2'd2; end
      4'd3:  begin field = 2'd1; sub = 2'd0; end
      4'd4:  begin field = 2'd1; sub = 2'd1; end
      4'd5:  begin field = 2'd1; sub = 2'd2; end
      4'd6:  begin field = 2'd2; sub = 2'd0; end
      4'd7:  begin field = 2'd2; sub = 2'd1; end
      4'd8:  begin field = 2'd2; sub = 2'd2; end
      4'd9:  begin field = 2'd3; sub = 2'd0; end
      4'd10: begin field = 2'd3; sub = 2'd1; end
      4'd11: begin field = 2'd3; sub = 2'd2; end
      default: ;
    endcase
  end

  assign is_sp   = (byte_r == 8'h20) || (byte_r >= 8'h09 && byte_r <= 8'h0D);
  assign is_dig  = (byte_r >= pgmchk_pkg::CH_ZERO) && (byte_r <= pgmchk_pkg::CH_NINE);
  assign neg_eff = neg_r && (acc_r != 13'd0 || ovf_r);
  assign acc_mul = {4'd0, acc_r} * 17'd10 + {13'd0, byte_r[3:0] - 4'd0};
  assign sum_add = {1'b0, sum_r} + {24'd0, acc_r[7:0]};

  // token finish: sets tok_err/tok_st and writes state on success
  always_comb begin
    phase_nxt = phase_r;
    cmt_nxt   = cmt_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    neg_nxt   = neg_r;
    wid_nxt   = wid_r;
    hgt_nxt   = hgt_r;
    maxv_nxt  = maxv_r;
    rem_nxt   = rem_r;
    sum_nxt   = sum_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    given_nxt = given_r;
    area_nxt  = area_r;
    emit      = 1'b0;
    emit_st   = pgmchk_pkg::ST_OK;
    tok_err   = 1'b0;
    tok_st    = pgmchk_pkg::ST_OK;

    // finish of the open token, used on separator and end of file
    if (sub == 2'd2 && phase_r >= 4'd2 && phase_r < 4'd14) begin
      acc_nxt = 13'd0;
      ovf_nxt = 1'b0;
      neg_nxt = 1'b0;
      priority case (field)
        2'd0, 2'd1: begin
          if (neg_eff || acc_r == 13'd0 || ovf_r || acc_r > 13'(pgmchk_pkg::MAX_DIM)) begin
            tok_err = 1'b1; tok_st = pgmchk_pkg::ST_BAD_HDR;
          end else begin
            if (field == 2'd0) wid_nxt = acc_r; else hgt_nxt = acc_r;
            phase_nxt = (field == 2'd0) ? 4'd5 : 4'd8;
          end
        end
        2'd2: begin
          if (neg_eff || acc_r == 13'd0) begin
            tok_err = 1'b1; tok_st = pgmchk_pkg::ST_BAD_HDR;
          end else if (ovf_r || acc_r > 13'd256) begin
            tok_err = 1'b1; tok_st = pgmchk_pkg::ST_MAX_BIG;
          end else begin
            maxv_nxt  = (acc_r == 13'd256) ? 9'd255 : acc_r[8:0];
            low_nxt   = ((acc_r == 13'd256) ? 9'd255 : acc_r[8:0]) + 9'd1;
            high_nxt  = 8'd0;
            sum_nxt   = 32'd0;
            rem_nxt   = area_r;
            phase_nxt = 4'd11;
          end
        end
        default: begin
          if (rem_r == 25'd0) begin
            tok_err = 1'b1; tok_st = pgmchk_pkg::ST_TOO_MANY;
          end else if (neg_eff) begin
            tok_err = 1'b1; tok_st = pgmchk_pkg::ST_NEGATIVE;
          end else if (ovf_r || acc_r > {4'd0, maxv_r}) begin
            tok_err = 1'b1; tok_st = pgmchk_pkg::ST_ABOVE_MAX;
          end else begin
            if (acc_r[7:0] > high_r) high_nxt = acc_r[7:0];
            if (acc_r[8:0] < low_r)  low_nxt  = acc_r[8:0];
            sum_nxt   = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
            rem_nxt   = rem_r - 25'd1;
            phase_nxt = 4'd11;
          end
        end
      endcase
    end

    if (eof_r) begin
      if (!given_r && phase_r < 4'd14) begin
        emit = 1'b1;
        if (phase_r < 4'd2)       emit_st = pgmchk_pkg::ST_BAD_MAGIC;
        else if (sub == 2'd1)     emit_st = pgmchk_pkg::ST_BAD_CHAR;
        else if (tok_err)         emit_st = tok_st;
        else if (phase_nxt < 4'd11) emit_st = pgmchk_pkg::ST_BAD_HDR;
        else if (rem_nxt != 25'd0)  emit_st = pgmchk_pkg::ST_TOO_FEW;
        else                      emit_st = pgmchk_pkg::ST_OK;
      end
    end else if (given_r || phase_r >= 4'd14) begin
      // ignore until end of file
    end else if (cmt_r) begin
      if (byte_r == pgmchk_pkg::CH_LF) cmt_nxt = 1'b0;
    end else if (phase_r == 4'd0) begin
      if (byte_r != pgmchk_pkg::CH_P) begin
        emit = 1'b1; emit_st = pgmchk_pkg::ST_BAD_MAGIC;
      end else phase_nxt = 4'd1;
    end else if (phase_r == 4'd1) begin
      if (byte_r != pgmchk_pkg::CH_TWO) begin
        emit = 1'b1; emit_st = pgmchk_pkg::ST_BAD_MAGIC;
      end else phase_nxt = 4'd2;
    end else if (is_sp || byte_r == pgmchk_pkg::CH_HASH) begin
      if (sub == 2'd1) begin
        emit = 1'b1; emit_st = pgmchk_pkg::ST_BAD_CHAR;
      end else if (tok_err) begin
        emit = 1'b1; emit_st = tok_st;
      end else if (byte_r == pgmchk_pkg::CH_HASH) cmt_nxt = 1'b1;
    end else if (byte_r == pgmchk_pkg::CH_MINUS) begin
      if (sub != 2'd0) begin
        emit = 1'b1; emit_st = pgmchk_pkg::ST_BAD_CHAR;
      end else begin
        neg_nxt   = 1'b1;
        phase_nxt = phase_r + 4'd1;
      end
    end else if (is_dig) begin
      // override any finish: digits never finish a token
      wid_nxt = wid_r; hgt_nxt = hgt_r; maxv_nxt = maxv_r; rem_nxt = rem_r;
      sum_nxt = sum_r; low_nxt = low_r; high_nxt = high_r;
      ovf_nxt = ovf_r; neg_nxt = neg_r;
      if (acc_mul > {4'd0, pgmchk_pkg::ACC_LIMIT}) begin
        acc_nxt = pgmchk_pkg::ACC_LIMIT; ovf_nxt = 1'b1;
      end else acc_nxt = acc_mul[12:0];
      phase_nxt = phase_r + 4'd2 - {2'd0, sub};
    end else begin
      emit = 1'b1; emit_st = pgmchk_pkg::ST_BAD_CHAR;
    end

    // non-finishing branches must not take the token finish
    if (!eof_r && (given_r || phase_r >= 4'd14 || cmt_r || phase_r < 4'd2 ||
        (!(is_sp || byte_r == pgmchk_pkg::CH_HASH) && !is_dig))) begin
      if (!(phase_r < 4'd2 && !given_r && !cmt_r && phase_r < 4'd14) || 1'b1) begin
        if (sub == 2'd2 && phase_r >= 4'd2 && phase_r < 4'd14) begin
          acc_nxt = acc_r; ovf_nxt = ovf_r; neg_nxt = neg_r;
          wid_nxt = wid_r; hgt_nxt = hgt_r; maxv_nxt = maxv_r; rem_nxt = rem_r;
          sum_nxt = sum_r; low_nxt = low_r; high_nxt = high_r;
          if (!(given_r || phase_r >= 4'd14 || cmt_r)) phase_nxt = phase_r;
          else phase_nxt = phase_r;
        end
      end
    end
    if (!eof_r && !given_r && phase_r < 4'd14 && !cmt_r && phase_r >= 4'd2 &&
        byte_r == pgmchk_pkg::CH_MINUS && sub == 2'd0)
      phase_nxt = phase_r + 4'd1;

    if (emit) begin
      given_nxt = 1'b1;
      phase_nxt = 4'd14;
    end
    if (eof_r) begin
      phase_nxt = 4'd0; cmt_nxt = 1'b0; acc_nxt = 13'd0; ovf_nxt = 1'b0;
      neg_nxt = 1'b0; given_nxt = 1'b0;
    end
    area_nxt = {12'd0, wid_nxt} * {12'd0, hgt_nxt};
  end

  // area and width*height: area_r mirrors wid_r*hgt_r for the max token
  logic [31:0] rst_vals;
  assign rst_vals = 32'd0;

  // divider: quotient of (sum<<8)/area, 40 bits, one bit per cycle
  logic [39:0] dq_r;
  logic [25:0] drem_r;
  logic [24:0] dsor_r;
  logic [5:0]  dcnt_r;
  logic [25:0] dtry;
  assign dtry = {drem_r[24:0], dq_r[39]} - {1'b0, dsor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 4'd0; cmt_r <= 1'b0; acc_r <= 13'd0; ovf_r <= 1'b0; neg_r <= 1'b0;
      wid_r <= 13'd0; hgt_r <= 13'd0; maxv_r <= 9'd0; rem_r <= 25'd0;
      sum_r <= rst_vals; low_r <= 9'd0; high_r <= 8'd0; given_r <= 1'b0;
      area_r <= 25'd0; dcnt_r <= 6'd0;
    end else begin
      if (in_valid && in_ready) begin
        byte_r <= in_data_byte;
        eof_r  <= in_end_of_file;
      end
      if (cmd.step) begin
        phase_r <= phase_nxt; cmt_r <= cmt_nxt; acc_r <= acc_nxt; ovf_r <= ovf_nxt;
        neg_r <= neg_nxt; given_r <= given_nxt;
        if (emit) begin
          st_r              <= emit_st;
          out_lowest_pixel  <= low_nxt;
          out_highest_pixel <= high_nxt;
          out_pixel_total   <= sum_nxt;
          out_average_fixed <= 16'd0;
        end
        if (eof_r) begin
          wid_r <= 13'd0; hgt_r <= 13'd0; maxv_r <= 9'd0; rem_r <= 25'd0;
          sum_r <= 32'd0; low_r <= 9'd0; high_r <= 8'd0; area_r <= 25'd0;
        end else begin
          wid_r <= wid_nxt; hgt_r <= hgt_nxt; maxv_r <= maxv_nxt; rem_r <= rem_nxt;
          sum_r <= sum_nxt; low_r <= low_nxt; high_r <= high_nxt; area_r <= area_nxt;
        end
      end
      if (cmd.div_start) begin
        dq_r   <= {sum_nxt, 8'd0};
        drem_r <= 26'd0;
        dsor_r <= area_r;
        dcnt_r <= 6'd40;
      end else if (cmd.div_run && dcnt_r != 6'd0) begin
        if (!dtry[25]) begin
          drem_r <= dtry;
          dq_r   <= {dq_r[38:0], 1'b1};
        end else begin
          drem_r <= {drem_r[24:0], dq_r[39]};
          dq_r   <= {dq_r[38:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 6'd1;
        if (dcnt_r == 6'd1)
          out_average_fixed <= dtry[25] ? {dq_r[14:0], 1'b0} : {dq_r[14:0], 1'b1};
      end
    end
  end

  assign sts.emit     = emit;
  assign sts.need_div = (emit_st == pgmchk_pkg::ST_OK) && eof_r && (wid_r != 13'd0);
  assign sts.div_done = (dcnt_r == 6'd1);
  assign out_status   = st_r;

endmodule

@@ rtl/core/pgm_ascii_stream_checker_unit.sv @@
// ----------------------------------------------------------------------------
// pgm_ascii_stream_checker_unit
// Checks an ASCII graymap byte stream and reports one status per file.
// ----------------------------------------------------------------------------
// Bytes: each byte is accepted, then applied in a parser step before the next
//   byte is taken. A result is valid in the cycle after its step; an ok result
//   at end of file first waits on the bit-serial average divider.
// Reset: synchronous active-low rst_n clears the parser and controller.
module pgm_ascii_stream_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [8:0]  out_lowest_pixel,
  output logic [7:0]  out_highest_pixel,
  output logic [31:0] out_pixel_total,
  output logic [15:0] out_average_fixed
);

  pgmchk_pkg::dp_cmd_t cmd;
  pgmchk_pkg::dp_sts_t sts;

  pgmchk_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  pgmchk_dp u_dp (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_end_of_file,
    .cmd, .sts, .out_status, .out_lowest_pixel, .out_highest_pixel,
    .out_pixel_total, .out_average_fixed
  );

endmodule
